>>> rtl/rqs_pkg.sv
// Package with shared types and constants for the ready queue scheduler.
package rqs_pkg;

  localparam int unsigned IdW   = 8;
  localparam int unsigned PrioW = 8;
  localparam int unsigned TimeW = 16;
  localparam int unsigned AgedW = 26;

  typedef enum logic [1:0] {
    FUNC_WAKE     = 2'd0,
    FUNC_DISPATCH = 2'd1,
    FUNC_PREEMPT  = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_RR    = 2'd1,
    POL_AGING = 2'd2,
    POL_SRTF  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_CPUS   = 2'd2,
    REG_SLICE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] left;
    logic [TimeW-1:0] stamp;
  } task_t;

  localparam int unsigned TaskW = $bits(task_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RUN_RD,
    ST_RUN_MUL,
    ST_RUN_CMP,
    ST_WAKE_DONE,
    ST_SCAN_RD,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_t;

endpackage

>>> rtl/rqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ready_queue_cpu_scheduler.sv
// Top level of the ready queue CPU scheduler with a sequential scan engine.
//
//  channel | ports                                           | handshake
//  --------+-------------------------------------------------+------------------------
//  command | func cpu task_id base_priority arrival ...      | start high, busy low
//  result  | dispatch_valid ... queued_count                 | done strobe, one cycle
//  config  | cfg_we cfg_index cfg_data                       | cfg_we high
//
// After the accepting edge busy stays high through the push state, the work below and the
// closing state; done rises in the cycle after that. A wake check runs multiply and compare on
// the first running record, read, multiply and compare on each further one and a final compare.
// A selection reads, multiplies and compares each ready entry, reads and writes back each entry
// moved to close the gap and loads the running record. Reset clears counters and valid bits and
// sets the configuration to its defaults; the receiver cannot stall.
module ready_queue_cpu_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_CPUS    = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [16:0]              cfg_data,
  input  logic [1:0]               func,
  input  logic [1:0]               cpu,
  input  logic [7:0]               task_id,
  input  logic [7:0]               base_priority,
  input  logic [15:0]              arrival,
  input  logic [15:0]              time_left,
  input  logic [15:0]              now,
  output logic                     dispatch_valid,
  output logic [7:0]               dispatch_task,
  output logic signed [16:0]       dispatch_slice,
  output logic                     preempt_request,
  output logic [1:0]               preempt_target,
  output logic                     queue_full,
  output logic [4:0]               queued_count
);
  import rqs_pkg::*;

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CAW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int unsigned CCW = $clog2(MAX_CPUS + 1);

  // Configuration.
  policy_t            policy;
  logic [7:0]         age_mult;
  logic [2:0]         cpus_in_use;
  logic [16:0]        slice_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POL_FCFS;
      age_mult     <= '0;
      cpus_in_use  <= 3'd4;
      slice_length <= 17'h1FFFF;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POLICY: policy       <= policy_t'(cfg_data[1:0]);
        REG_WEIGHT: age_mult     <= cfg_data[7:0];
        REG_CPUS:   cpus_in_use  <= cfg_data[2:0];
        REG_SLICE:  slice_length <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic [CCW-1:0] cpu_lim;
  always_comb begin
    if (32'(cpus_in_use) > MAX_CPUS) cpu_lim = CCW'(MAX_CPUS);
    else cpu_lim = CCW'(cpus_in_use);
  end

  // State.
  state_t             state, state_next;
  logic [QCW-1:0]     rcount;
  logic [MAX_CPUS-1:0] rvalid;
  task_t              run_rec [MAX_CPUS];

  // Latched transaction.
  func_t              op;
  logic [CAW-1:0]     op_cpu;
  logic [15:0]        op_now;
  task_t              op_task;
  logic               op_push;

  task_t              start_task;
  logic               start_push;

  always_comb begin
    start_task = '{id: task_id, prio: base_priority, arrival: arrival,
                   left: time_left, stamp: now};
    start_push = (func == FUNC_WAKE);
    if ((func == FUNC_PREEMPT) && (32'(cpu) < 32'(cpu_lim)) && rvalid[CAW'(cpu)]) begin
      start_task       = run_rec[CAW'(cpu)];
      start_task.left  = time_left;
      start_task.stamp = now;
      start_push       = 1'b1;
    end
  end

  logic               push_ok;
  assign push_ok = op_push && (32'(rcount) < QUEUE_DEPTH);

  // Ready table RAM.
  logic               ram_we;
  logic [QAW-1:0]     ram_waddr, ram_raddr;
  task_t              ram_wdata;
  logic [TaskW-1:0]   ram_rdata;

  rqs_ram #(.WIDTH(TaskW), .DEPTH(QUEUE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan state and shared compare unit.
  logic [QCW-1:0]     idx;
  logic [CCW-1:0]     cidx;
  logic [QAW-1:0]     best_idx;
  logic [CAW-1:0]     best_cpu;
  logic signed [AgedW-1:0] best_key;
  logic [23:0]        prod;
  logic [23:0]        prod_key;
  task_t              best_task;
  logic               r_full, r_dv, r_pr;

  task_t              cand;
  logic [15:0]        diff;
  logic signed [AgedW-1:0] key_now;

  // The woken task carries the current time as its stamp, so it has not aged.
  assign prod_key = (state == ST_WAKE_DONE) ? '0 : prod;

  assign diff = op_now - cand.stamp;
  always_comb begin
    unique case (policy)
      POL_FCFS:  key_now = AgedW'(cand.arrival);
      POL_SRTF:  key_now = AgedW'(cand.left);
      POL_AGING: key_now = $signed(AgedW'(cand.prio)) - $signed(AgedW'(prod_key));
      default:   key_now = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= diff * age_mult;
  end

  always_comb begin
    cand = task_t'(ram_rdata);
    if (state == ST_RUN_MUL || state == ST_RUN_CMP) cand = run_rec[cidx[CAW-1:0]];
    if (state == ST_WAKE_DONE) cand = op_task;
  end

  logic scan_better;
  assign scan_better = (idx == 0) || (policy != POL_RR && key_now < best_key);

  logic wake_pre;
  always_comb begin
    wake_pre = (policy == POL_SRTF) ? (key_now < best_key) : (key_now < best_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_PUSH;
      ST_PUSH: begin
        if (op == FUNC_WAKE) begin
          if (push_ok && (policy == POL_AGING || policy == POL_SRTF) && cpu_lim != 0)
            state_next = ST_RUN_MUL;
          else state_next = ST_DONE;
        end else if ((op == FUNC_DISPATCH || op == FUNC_PREEMPT) &&
                     32'(op_cpu) < 32'(cpu_lim)) begin
          state_next = (rcount != 0 || push_ok) ? ST_SCAN_RD : ST_DONE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RUN_RD:  state_next = ST_RUN_MUL;
      ST_RUN_MUL: state_next = ST_RUN_CMP;
      ST_RUN_CMP: begin
        if (!rvalid[cidx[CAW-1:0]]) state_next = ST_DONE;
        else if (cidx + 1'b1 >= cpu_lim) state_next = ST_WAKE_DONE;
        else state_next = ST_RUN_RD;
      end
      ST_WAKE_DONE: state_next = ST_DONE;
      ST_SCAN_RD:  state_next = ST_SCAN_MUL;
      ST_SCAN_MUL: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = (idx + 1'b1 >= rcount) ? ST_MOVE_RD : ST_SCAN_RD;
      ST_MOVE_RD:  state_next = (32'(idx) + 1 >= 32'(rcount)) ? ST_DONE : ST_MOVE_WR;
      ST_MOVE_WR:  state_next = ST_MOVE_RD;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rcount[QAW-1:0];
    ram_wdata = op_task;
    ram_raddr = idx[QAW-1:0];
    if (state == ST_PUSH && push_ok) ram_we = 1'b1;
    if (state == ST_MOVE_RD) ram_raddr = QAW'(idx + 1'b1);
    if (state == ST_MOVE_WR) begin
      ram_we    = 1'b1;
      ram_waddr = idx[QAW-1:0];
      ram_wdata = task_t'(ram_rdata);
    end
    if (state == ST_SCAN_CMP) ram_raddr = scan_better ? idx[QAW-1:0] : best_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcount <= '0;
      rvalid <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (start) begin
          op      <= func_t'(func);
          op_cpu  <= CAW'(cpu);
          op_now  <= now;
          op_task <= start_task;
          op_push <= start_push;
          r_full <= 1'b0; r_dv <= 1'b0; r_pr <= 1'b0;
          preempt_target <= '0;
          dispatch_task  <= '0;
          dispatch_slice <= '0;
        end
        ST_PUSH: begin
          if (op_push) begin
            if (32'(rcount) >= QUEUE_DEPTH) begin
              r_full  <= 1'b1;
              op_push <= 1'b0;
            end else begin
              rcount <= rcount + 1'b1;
            end
          end
          cidx <= '0; idx <= '0; best_idx <= '0; best_cpu <= '0;
          best_key <= '0;
          if ((op == FUNC_DISPATCH || op == FUNC_PREEMPT) &&
              32'(op_cpu) < 32'(cpu_lim)) begin
            rvalid[op_cpu] <= 1'b0;
            dispatch_slice <= slice_length;
          end
        end
        ST_RUN_CMP: begin
          if (rvalid[cidx[CAW-1:0]]) begin
            if ((policy == POL_SRTF) ? (key_now > best_key)
                                    : (cidx == 0 || key_now > best_key)) begin
              best_key <= key_now;
              best_cpu <= cidx[CAW-1:0];
            end
          end
          cidx <= cidx + 1'b1;
        end
        ST_WAKE_DONE: begin
          if (wake_pre) begin
            r_pr <= 1'b1;
            preempt_target <= 2'(best_cpu);
          end
        end
        ST_SCAN_CMP: begin
          if (scan_better) begin
            best_key <= key_now;
            best_idx <= idx[QAW-1:0];
          end
          if (idx + 1'b1 >= rcount) begin
            idx <= scan_better ? idx : QCW'(best_idx);
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_MOVE_RD: begin
          if (!r_dv) begin
            best_task <= cand;
            r_dv <= 1'b1;
          end
          if (32'(idx) + 1 >= 32'(rcount)) begin
            rcount <= rcount - 1'b1;
            run_rec[op_cpu] <= r_dv ? best_task : cand;
            rvalid[op_cpu]  <= 1'b1;
            dispatch_task   <= r_dv ? best_task.id : cand.id;
          end
        end
        ST_MOVE_WR: idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  assign busy            = (state != ST_IDLE);
  assign dispatch_valid  = r_dv;
  assign preempt_request = r_pr;
  assign queue_full      = r_full;
  assign queued_count    = 5'(rcount);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rcount) <= QUEUE_DEPTH) else $error("ready count above depth");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held more than one cycle");
  a_pre_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(preempt_request && queue_full)) else $error("preempt on full table");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for the ready queue CPU scheduler: directed table, then random phases.
module tb;
  import rqs_pkg::*;

  typedef struct packed {
    func_t          fn;
    logic [1:0]     cpu;
    logic [7:0]     id;
    logic [7:0]     prio;
    logic [15:0]    arr;
    logic [15:0]    left;
    logic [15:0]    nw;
  } op_t;

  typedef struct packed {
    logic           dv;
    logic [7:0]     dt;
    logic [16:0]    ds;
    logic           pr;
    logic [1:0]     pt;
    logic           full;
    logic [4:0]     qc;
  } sched_out_t;

  typedef struct packed {
    op_t            op;
    logic           has_exp;
    sched_out_t     exp;
  } row_t;

  localparam int Depth = 16;
  localparam int Cpus  = 4;

  logic clk, rst, start, busy, done, cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic [1:0]  func, cpu;
  logic [7:0]  task_id, base_priority;
  logic [15:0] arrival, time_left, now;
  logic        dispatch_valid, preempt_request, queue_full;
  logic [7:0]  dispatch_task;
  logic signed [16:0] dispatch_slice;
  logic [1:0]  preempt_target;
  logic [4:0]  queued_count;

  ready_queue_cpu_scheduler u_top (.*);

  // Shadow copy of the scheduler state and registers.
  policy_t     m_policy;
  logic [7:0]  m_weight;
  logic [2:0]  m_cpus;
  logic [16:0] m_slice;
  task_t       m_ready[Depth];
  int          m_count;
  task_t       m_run[Cpus];
  logic [3:0]  m_valid;

  sched_out_t  pending[$];
  int          errors;
  logic [15:0] clock_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int aged(task_t t, logic [15:0] nw);
    logic [15:0] d;
    d = nw - t.stamp;
    return int'(t.prio) - int'(d) * int'(m_weight);
  endfunction

  function automatic bit enqueue_task(task_t t);
    if (m_count >= Depth) return 1'b0;
    m_ready[m_count] = t;
    m_count++;
    return 1'b1;
  endfunction

  function automatic sched_out_t schedule(op_t o);
    sched_out_t r;
    task_t t;
    int n, best, target, max_aged, a;
    logic [15:0] max_left;
    bit idle, better;
    r = '0;
    n = (m_cpus > Cpus) ? Cpus : int'(m_cpus);
    if (o.fn == FUNC_WAKE) begin
      t = '{id: o.id, prio: o.prio, arrival: o.arr, left: o.left, stamp: o.nw};
      if (!enqueue_task(t)) begin
        r.full = 1'b1;
      end else if ((m_policy == POL_AGING || m_policy == POL_SRTF) && n > 0) begin
        idle = 1'b0;
        target = 0;
        max_left = '0;
        max_aged = 0;
        for (int i = 0; i < n; i++) begin
          if (!m_valid[i]) begin
            idle = 1'b1;
            break;
          end
          if (m_policy == POL_SRTF) begin
            if (m_run[i].left > max_left) begin
              max_left = m_run[i].left;
              target = i;
            end
          end else begin
            a = aged(m_run[i], o.nw);
            if (i == 0 || a > max_aged) begin
              max_aged = a;
              target = i;
            end
          end
        end
        if (!idle && (m_policy == POL_SRTF ? (t.left < max_left)
                                           : (aged(t, o.nw) < max_aged))) begin
          r.pr = 1'b1;
          r.pt = target[1:0];
        end
      end
    end else if ((o.fn == FUNC_DISPATCH || o.fn == FUNC_PREEMPT) && int'(o.cpu) < n) begin
      if (o.fn == FUNC_PREEMPT && m_valid[o.cpu]) begin
        t = m_run[o.cpu];
        t.left = o.left;
        t.stamp = o.nw;
        if (!enqueue_task(t)) r.full = 1'b1;
      end
      m_valid[o.cpu] = 1'b0;
      r.ds = m_slice;
      if (m_count > 0) begin
        best = 0;
        for (int i = 1; i < m_count; i++) begin
          case (m_policy)
            POL_FCFS:  better = m_ready[i].arrival < m_ready[best].arrival;
            POL_AGING: better = aged(m_ready[i], o.nw) < aged(m_ready[best], o.nw);
            POL_SRTF:  better = m_ready[i].left < m_ready[best].left;
            default:   better = 1'b0;
          endcase
          if (better) best = i;
        end
        m_run[o.cpu] = m_ready[best];
        for (int i = best; i < m_count - 1; i++) m_ready[i] = m_ready[i + 1];
        m_count--;
        m_valid[o.cpu] = 1'b1;
        r.dv = 1'b1;
        r.dt = m_run[o.cpu].id;
      end
    end
    r.qc = m_count[4:0];
    return r;
  endfunction

  // Expects to be called just after the clock rises; leaves start high for the caller to reuse or drop.
  task automatic issue(op_t o, bit has_exp, sched_out_t e);
    sched_out_t p;
    start <= 1'b1;
    func <= o.fn;
    cpu <= o.cpu;
    task_id <= o.id;
    base_priority <= o.prio;
    arrival <= o.arr;
    time_left <= o.left;
    now <= o.nw;
    do @(posedge clk); while (busy);
    p = schedule(o);
    if (has_exp && p != e) begin
      errors++;
      if (errors <= 10) $display("table row predicts %h, typed %h", p, e);
    end
    pending.push_back(p);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [16:0] val);
    start <= 1'b0;
    do @(posedge clk); while (busy || pending.size() != 0);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POLICY: m_policy = policy_t'(val[1:0]);
      REG_WEIGHT: m_weight = val[7:0];
      REG_CPUS:   m_cpus = val[2:0];
      default:    m_slice = val;
    endcase
  endtask

  function automatic op_t random_op(int wake_pct);
    op_t o;
    int r;
    r = $urandom_range(0, 99);
    if (r < wake_pct) o.fn = FUNC_WAKE;
    else if (r < 95) o.fn = ($urandom_range(0, 1) != 0) ? FUNC_DISPATCH : FUNC_PREEMPT;
    else o.fn = FUNC_NONE;
    o.cpu = 2'($urandom_range(0, 3));
    o.id = 8'($urandom);
    o.prio = 8'($urandom);
    o.arr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    o.left = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    if ($urandom_range(0, 19) == 0) clock_now = 16'($urandom);
    else clock_now = clock_now + 16'($urandom_range(0, 40));
    o.nw = clock_now;
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", {dispatch_valid,
          dispatch_task, dispatch_slice, preempt_request, preempt_target, queue_full,
          queued_count});
      end else begin
        sched_out_t e, a;
        e = pending.pop_front();
        a = '{dv: dispatch_valid, dt: dispatch_task, ds: dispatch_slice,
              pr: preempt_request, pt: preempt_target, full: queue_full, qc: queued_count};
        if (a != e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h got %h", e, a);
        end
      end
    end
  end

  row_t rows[] = '{
    '{'{FUNC_DISPATCH, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{1'b0, 8'd0, 17'h1FFFF, 1'b0, 2'd0, 1'b0, 5'd0}},
    '{'{FUNC_PREEMPT, 2'd3, 8'd0, 8'd0, 16'd0, 16'hFFFF, 16'd0}, 1'b1,
      '{1'b0, 8'd0, 17'h1FFFF, 1'b0, 2'd0, 1'b0, 5'd0}},
    '{'{FUNC_NONE, 2'd1, 8'd9, 8'd9, 16'd9, 16'd9, 16'd9}, 1'b1,
      '{1'b0, 8'd0, 17'd0, 1'b0, 2'd0, 1'b0, 5'd0}},
    '{'{FUNC_WAKE, 2'd0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b1,
      '{1'b0, 8'd0, 17'd0, 1'b0, 2'd0, 1'b0, 5'd1}},
    '{'{FUNC_WAKE, 2'd3, 8'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b1,
      '{1'b0, 8'd0, 17'd0, 1'b0, 2'd0, 1'b0, 5'd2}},
    '{'{FUNC_DISPATCH, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd1}, 1'b1,
      '{1'b1, 8'd0, 17'h1FFFF, 1'b0, 2'd0, 1'b0, 5'd1}},
    '{'{FUNC_PREEMPT, 2'd0, 8'd0, 8'd0, 16'd0, 16'd1234, 16'd10}, 1'b1,
      '{1'b1, 8'd0, 17'h1FFFF, 1'b0, 2'd0, 1'b0, 5'd1}},
    '{'{FUNC_WAKE, 2'd0, 8'd7, 8'd3, 16'd5, 16'd100, 16'd11}, 1'b0, '0},
    '{'{FUNC_WAKE, 2'd0, 8'd8, 8'd3, 16'd5, 16'd50, 16'd12}, 1'b0, '0},
    '{'{FUNC_DISPATCH, 2'd1, 8'd0, 8'd0, 16'd0, 16'd0, 16'd13}, 1'b0, '0},
    '{'{FUNC_DISPATCH, 2'd2, 8'd0, 8'd0, 16'd0, 16'd0, 16'd14}, 1'b0, '0},
    '{'{FUNC_PREEMPT, 2'd1, 8'd0, 8'd0, 16'd0, 16'd0, 16'd15}, 1'b0, '0},
    '{'{FUNC_DISPATCH, 2'd3, 8'd0, 8'd0, 16'd0, 16'd0, 16'd16}, 1'b0, '0},
    '{'{FUNC_WAKE, 2'd0, 8'h55, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
    '{'{FUNC_WAKE, 2'd0, 8'hAA, 8'h55, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{'{FUNC_DISPATCH, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd20}, 1'b0, '0}
  };

  initial begin
    int wait_cycles, wake_pct;
    bit calm;
    rst <= 1'b1;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_POLICY;
    cfg_data <= '0;
    func <= FUNC_NONE;
    cpu <= '0;
    task_id <= '0;
    base_priority <= '0;
    arrival <= '0;
    time_left <= '0;
    now <= '0;
    errors = 0;
    clock_now = '0;
    m_policy = POL_FCFS;
    m_weight = '0;
    m_cpus = 3'd4;
    m_slice = 17'h1FFFF;
    m_count = 0;
    m_valid = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      issue(rows[i].op, rows[i].has_exp, rows[i].exp);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
    end

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_POLICY, 17'(ph % 4));
      write_reg(REG_WEIGHT, ph == 0 ? 17'd255 : ph == 1 ? 17'd0 : 17'($urandom_range(0, 255)));
      write_reg(REG_CPUS, ph == 0 ? 17'd4 : ph == 1 ? 17'd1 : 17'($urandom_range(1, 4)));
      write_reg(REG_SLICE, ph == 0 ? 17'h1FFFF : ph == 1 ? 17'd65535 : ph == 2 ? 17'd0
                           : 17'($urandom_range(0, 65536) - 1));
      wake_pct = (ph % 3 == 0) ? 70 : (ph % 3 == 1) ? 50 : 35;
      calm = (ph == 9);
      for (int k = 0; k < 170; k++) begin
        issue(random_op(wake_pct), 1'b0, '0);
        if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
      end
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (pending.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending.size() != 0) errors++;
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
